[rtl/mta_pkg.sv]
// ---------------------------------------------------------------------------
// mta_pkg
// Shared types and constants of the station address table with aging.
// ---------------------------------------------------------------------------
package mta_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ADDR_BYTES_DEF  = 6;

    localparam int ADDR_W    = 48;
    localparam int TIME_W    = 32;
    localparam int TIMEOUT_W = 23;
    localparam int COUNT_W   = 5;
    localparam int LIMIT_W   = 33;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 23'd10000;
    localparam int unsigned          MS_TO_US    = 1000;

    typedef enum logic [1:0] {
        OP_LEARN  = 2'd0,
        OP_SWEEP  = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        RES_REFRESHED    = 3'd0,
        RES_ADDED        = 3'd1,
        RES_FULL         = 3'd2,
        RES_REMOVED      = 3'd3,
        RES_NOT_FOUND    = 3'd4,
        RES_CLEARED      = 3'd5,
        RES_EXPIRED      = 3'd6,
        RES_NONE_EXPIRED = 3'd7
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DONE = 2'd2
    } t_state;

    typedef struct packed {
        logic    load;
        logic    adv;
        logic    refresh;
        logic    add;
        logic    remove;
        logic    clear_all;
        logic    expire;
        logic    emit;
        logic    emit_pend;
        t_result result;
        logic    last;
    } t_dp_cmd;

    typedef struct packed {
        t_op  op;
        logic rd_vld;
        logic rd_last;
        logic hit;
        logic expired;
        logic free_vld;
        logic pend_vld;
        logic out_free;
    } t_dp_status;

endpackage

[rtl/mta_ctrl.sv]
// ---------------------------------------------------------------------------
// mta_ctrl
// Sequencer that walks the table for one transaction and issues datapath
// commands.
// ---------------------------------------------------------------------------
module mta_ctrl import mta_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  t_dp_status i_st,
    output t_dp_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    logic addr_op;
    logic sweep_op;
    logic hit_end;
    logic pend_stall;

    assign addr_op    = (i_st.op == OP_LEARN) || (i_st.op == OP_REMOVE);
    assign sweep_op   = (i_st.op == OP_SWEEP);
    assign hit_end    = i_st.rd_vld && i_st.hit && addr_op;
    assign pend_stall = i_st.rd_vld && i_st.expired && sweep_op && i_st.pend_vld
                        && !i_st.out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_st.op == OP_CLEAR) begin
                    n_state = S_DONE;
                end else if (hit_end) begin
                    if (i_st.out_free) begin
                        n_state = S_IDLE;
                    end
                end else if (pend_stall) begin
                    n_state = S_SCAN;
                end else if (i_st.rd_vld && i_st.rd_last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_SCAN: begin
                if (i_st.op == OP_CLEAR) begin
                    o_cmd.adv = 1'b0;
                end else if (!i_st.rd_vld) begin
                    o_cmd.adv = 1'b1;
                end else if (hit_end) begin
                    if (i_st.out_free) begin
                        o_cmd.emit = 1'b1;
                        o_cmd.last = 1'b1;
                        if (i_st.op == OP_LEARN) begin
                            o_cmd.refresh = 1'b1;
                            o_cmd.result  = RES_REFRESHED;
                        end else begin
                            o_cmd.remove = 1'b1;
                            o_cmd.result = RES_REMOVED;
                        end
                    end
                end else if (i_st.expired && sweep_op) begin
                    if (!i_st.pend_vld) begin
                        o_cmd.expire = 1'b1;
                        o_cmd.adv    = 1'b1;
                    end else if (i_st.out_free) begin
                        o_cmd.expire    = 1'b1;
                        o_cmd.adv       = 1'b1;
                        o_cmd.emit_pend = 1'b1;
                        o_cmd.last      = 1'b0;
                    end
                end else begin
                    o_cmd.adv = 1'b1;
                end
            end
            S_DONE: begin
                if (i_st.out_free) begin
                    o_cmd.last = 1'b1;
                    case (i_st.op)
                        OP_LEARN: begin
                            o_cmd.emit = 1'b1;
                            if (i_st.free_vld) begin
                                o_cmd.add    = 1'b1;
                                o_cmd.result = RES_ADDED;
                            end else begin
                                o_cmd.result = RES_FULL;
                            end
                        end
                        OP_REMOVE: begin
                            o_cmd.emit   = 1'b1;
                            o_cmd.result = RES_NOT_FOUND;
                        end
                        OP_SWEEP: begin
                            if (i_st.pend_vld) begin
                                o_cmd.emit_pend = 1'b1;
                            end else begin
                                o_cmd.emit   = 1'b1;
                                o_cmd.result = RES_NONE_EXPIRED;
                            end
                        end
                        OP_CLEAR: begin
                            o_cmd.clear_all = 1'b1;
                            o_cmd.emit      = 1'b1;
                            o_cmd.result    = RES_CLEARED;
                        end
                        default: o_cmd.emit = 1'b0;
                    endcase
                end
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

[rtl/mta_dp.sv]
// ---------------------------------------------------------------------------
// mta_dp
// Table storage, valid bits, slot scan pipeline and output register.
// ---------------------------------------------------------------------------
module mta_dp import mta_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADDR_BYTES  = ADDR_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_dp_cmd              i_cmd,
    output t_dp_status           o_st,
    input  t_op                  i_op,
    input  logic [ADDR_W-1:0]    i_addr,
    input  logic [TIME_W-1:0]    i_now,
    input  logic [TIMEOUT_W-1:0] i_timeout,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output t_result              o_out_result,
    output logic [ADDR_W-1:0]    o_out_addr,
    output logic [COUNT_W-1:0]   o_out_count,
    output logic                 o_out_last
);

    localparam int KEY_W = (ADDR_BYTES * 8 > ADDR_W) ? ADDR_W : ADDR_BYTES * 8;
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int CNTW  = $clog2(TABLE_DEPTH + 1);

    logic [KEY_W-1:0]  addr_mem [TABLE_DEPTH];
    logic [TIME_W-1:0] time_mem [TABLE_DEPTH];

    t_op               r_op;
    logic [KEY_W-1:0]  r_key;
    logic [TIME_W-1:0] r_now;
    logic [LIMIT_W-1:0] r_limit;

    logic [CNTW-1:0]   r_idx;
    logic              r_rd_vld;
    logic [IW-1:0]     r_rd_idx;
    logic [KEY_W-1:0]  r_rd_key;
    logic [TIME_W-1:0] r_rd_time;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [TABLE_DEPTH-1:0] n_valid;
    logic [CNTW-1:0]        r_count;
    logic [CNTW-1:0]        n_count;

    logic              r_free_vld;
    logic [IW-1:0]     r_free_idx;
    logic              r_pend_vld;
    logic [KEY_W-1:0]  r_pend_key;
    logic [CNTW-1:0]   r_pend_count;

    logic              r_out_vld;
    t_result           r_out_result;
    logic [ADDR_W-1:0] r_out_addr;
    logic [COUNT_W-1:0] r_out_count;
    logic              r_out_last;

    logic              issue;
    logic              slot_vld;
    logic [TIME_W-1:0] age;
    logic              out_free;
    logic              time_we;
    logic [IW-1:0]     time_wa;

    assign issue    = i_cmd.adv && (r_idx < CNTW'(TABLE_DEPTH));
    assign slot_vld = r_valid[r_rd_idx];
    assign age      = r_now - r_rd_time;
    assign out_free = !r_out_vld || i_out_ready;
    assign time_we  = i_cmd.refresh || i_cmd.add;
    assign time_wa  = i_cmd.add ? r_free_idx : r_rd_idx;

    assign o_st.op       = r_op;
    assign o_st.rd_vld   = r_rd_vld;
    assign o_st.rd_last  = (r_rd_idx == IW'(TABLE_DEPTH - 1));
    assign o_st.hit      = r_rd_vld && slot_vld && (r_rd_key == r_key);
    assign o_st.expired  = r_rd_vld && slot_vld && ({1'b0, age} > r_limit);
    assign o_st.free_vld = r_free_vld;
    assign o_st.pend_vld = r_pend_vld;
    assign o_st.out_free = out_free;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_op;
            r_key   <= i_addr[KEY_W-1:0];
            r_now   <= i_now;
            r_limit <= LIMIT_W'(i_timeout) * LIMIT_W'(MS_TO_US);
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_key  <= addr_mem[r_idx[IW-1:0]];
            r_rd_time <= time_mem[r_idx[IW-1:0]];
        end
        if (i_cmd.add) begin
            addr_mem[r_free_idx] <= r_key;
        end
        if (time_we) begin
            time_mem[time_wa] <= r_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_free_vld <= 1'b0;
            r_pend_vld <= 1'b0;
        end else if (i_cmd.load) begin
            r_idx      <= '0;
            r_rd_vld   <= 1'b0;
            r_free_vld <= 1'b0;
            r_pend_vld <= 1'b0;
        end else begin
            if (i_cmd.adv) begin
                r_rd_vld <= issue;
                if (issue) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_rd_vld && !slot_vld && !r_free_vld) begin
                    r_free_vld <= 1'b1;
                end
            end
            if (i_cmd.expire) begin
                r_pend_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_idx <= r_idx[IW-1:0];
        end
        if (i_cmd.adv && r_rd_vld && !slot_vld && !r_free_vld) begin
            r_free_idx <= r_rd_idx;
        end
        if (i_cmd.expire) begin
            r_pend_key   <= r_rd_key;
            r_pend_count <= n_count;
        end
    end

    always_comb begin
        n_valid = r_valid;
        n_count = r_count;
        if (i_cmd.clear_all) begin
            n_valid = '0;
            n_count = '0;
        end else if (i_cmd.add) begin
            n_valid[r_free_idx] = 1'b1;
            n_count = r_count + 1'b1;
        end else if (i_cmd.remove || i_cmd.expire) begin
            n_valid[r_rd_idx] = 1'b0;
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_count   <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_count <= n_count;
            if (i_cmd.emit || i_cmd.emit_pend) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_result <= i_cmd.result;
            r_out_addr   <= '0;
            r_out_count  <= COUNT_W'(n_count);
            r_out_last   <= i_cmd.last;
        end else if (i_cmd.emit_pend) begin
            r_out_result <= RES_EXPIRED;
            r_out_addr   <= ADDR_W'(r_pend_key);
            r_out_count  <= COUNT_W'(r_pend_count);
            r_out_last   <= i_cmd.last;
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_result = r_out_result;
    assign o_out_addr   = r_out_addr;
    assign o_out_count  = r_out_count;
    assign o_out_last   = r_out_last;

endmodule

[rtl/mac_table_with_aging.sv]
// ---------------------------------------------------------------------------
// mac_table_with_aging
// Station address learning table with last-seen timestamps and aging sweep.
//
// Channel   Direction  Handshake                      Content
// s_axis    in         s_axis_tvalid / s_axis_tready  operation, address, time
// m_axis    out        m_axis_tvalid / m_axis_tready  result, address, count
// apb       in         psel / penable / pready        aging timeout at addresses 0-3
//
// One transaction at a time is processed. Learn, remove and sweep scan all
// slots through the registered memory read port; learn and remove end early
// on a match. Clear does not scan the slots.
// Reset clears all valid bits at once; the stored addresses need no clearing.
// A stalled m_axis holds the scan until the output register is free.
// ---------------------------------------------------------------------------
module mac_table_with_aging import mta_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int ADDR_BYTES  = ADDR_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // station_addr [47:0], now_us [79:48]
    input  logic [79:0] s_axis_tdata,
    // operation [1:0]
    input  logic [1:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // expired_addr [47:0], entry_count [52:48], zero [55:53]
    output logic [55:0] m_axis_tdata,
    // status [2:0]
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [TIMEOUT_W-1:0] r_timeout;
    t_dp_cmd              cmd;
    t_dp_status           st;
    t_result              out_result;
    logic [ADDR_W-1:0]    out_addr;
    logic [COUNT_W-1:0]   out_count;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : 32'(r_timeout);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RST;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_timeout <= pwdata[TIMEOUT_W-1:0];
        end
    end

    mta_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_st       (st),
        .o_cmd      (cmd)
    );

    mta_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .ADDR_BYTES  (ADDR_BYTES)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_st         (st),
        .i_op         (t_op'(s_axis_tuser)),
        .i_addr       (s_axis_tdata[47:0]),
        .i_now        (s_axis_tdata[79:48]),
        .i_timeout    (r_timeout),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_result (out_result),
        .o_out_addr   (out_addr),
        .o_out_count  (out_count),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tuser = out_result;
    assign m_axis_tdata = {3'b000, out_count, out_addr};

    a_single_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.emit && cmd.emit_pend))
        else $error("two results pushed in one cycle");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.emit || cmd.emit_pend) |-> st.out_free)
        else $error("result pushed into a full output register");

    a_clear_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clear_all |=> (m_axis_tvalid && m_axis_tdata[52:48] == 5'd0))
        else $error("clear did not report an empty table");

endmodule

[bench/mta_table_checker.sv]
// ---------------------------------------------------------------------------
// mta_table_checker
// Watches the input, output and register channels of the station address
// table, keeps its own copy of the slots and the timeout, predicts the
// results of every accepted transaction and compares each accepted result,
// field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module mta_table_checker import mta_pkg::*; #(
    parameter int         TABLE_DEPTH  = TABLE_DEPTH_DEF,
    parameter int         ADDR_BYTES   = ADDR_BYTES_DEF,
    parameter logic [2:0] TIMEOUT_ADDR = 3'd0
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    // station_addr [47:0], now_us [79:48]
    input  logic [79:0] s_axis_tdata,
    // operation [1:0]
    input  logic [1:0]  s_axis_tuser,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // expired_addr [47:0], entry_count [52:48], zero [55:53]
    input  logic [55:0] m_axis_tdata,
    // status [2:0]
    input  logic [2:0]  m_axis_tuser,
    input  logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        t_result            status;
        logic [ADDR_W-1:0]  addr;
        logic [COUNT_W-1:0] count;
        logic               last;
    } t_table_result;

    localparam logic [ADDR_W-1:0] ADDR_MASK = (ADDR_BYTES >= 6) ? {ADDR_W{1'b1}} :
        ADDR_W'((64'd1 << (8 * ADDR_BYTES)) - 64'd1);

    logic                 slot_used    [TABLE_DEPTH];
    logic [ADDR_W-1:0]    slot_station [TABLE_DEPTH];
    logic [TIME_W-1:0]    slot_stamp   [TABLE_DEPTH];
    logic [TIMEOUT_W-1:0] aging_timeout = TIMEOUT_RST;
    t_table_result        pending_results [$];
    int                   fail_count = 0;

    function automatic logic [COUNT_W-1:0] live_entries();
        int n;
        n = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i]) n++;
        end
        return COUNT_W'(n);
    endfunction

    task automatic post_result(input t_result status, input logic [ADDR_W-1:0] addr,
                               input logic last);
        t_table_result r;
        r.status = status;
        r.addr   = addr;
        r.count  = live_entries();
        r.last   = last;
        pending_results.push_back(r);
    endtask

    task automatic apply_table_op(input t_op op, input logic [ADDR_W-1:0] station,
                                  input logic [TIME_W-1:0] now);
        int                 hit;
        int                 free_slot;
        int                 n_expired;
        logic [ADDR_W-1:0]  addr;
        logic [LIMIT_W-1:0] limit;
        logic [TIME_W-1:0]  age;
        t_table_result      r;
        hit       = -1;
        free_slot = -1;
        n_expired = 0;
        addr      = station & ADDR_MASK;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (slot_used[i] && slot_station[i] == addr && hit < 0) hit = i;
            if (!slot_used[i] && free_slot < 0) free_slot = i;
        end
        case (op)
            OP_LEARN: begin
                if (hit >= 0) begin
                    slot_stamp[hit] = now;
                    post_result(RES_REFRESHED, '0, 1'b1);
                end else if (free_slot >= 0) begin
                    slot_used[free_slot]    = 1'b1;
                    slot_station[free_slot] = addr;
                    slot_stamp[free_slot]   = now;
                    post_result(RES_ADDED, '0, 1'b1);
                end else begin
                    post_result(RES_FULL, '0, 1'b1);
                end
            end
            OP_REMOVE: begin
                if (hit >= 0) begin
                    slot_used[hit] = 1'b0;
                    post_result(RES_REMOVED, '0, 1'b1);
                end else begin
                    post_result(RES_NOT_FOUND, '0, 1'b1);
                end
            end
            OP_CLEAR: begin
                for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
                post_result(RES_CLEARED, '0, 1'b1);
            end
            default: begin
                limit = LIMIT_W'(aging_timeout) * LIMIT_W'(MS_TO_US);
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (slot_used[i]) begin
                        age = now - slot_stamp[i];
                        if ({1'b0, age} > limit) begin
                            slot_used[i] = 1'b0;
                            post_result(RES_EXPIRED, slot_station[i], 1'b0);
                            n_expired++;
                        end
                    end
                end
                if (n_expired == 0) begin
                    post_result(RES_NONE_EXPIRED, '0, 1'b1);
                end else begin
                    r = pending_results.pop_back();
                    r.last = 1'b1;
                    pending_results.push_back(r);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: result %s mismatch: got 0x%0h, expected 0x%0h",
                 $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_table_result want;
        if (!i_rst_n) begin
            for (int i = 0; i < TABLE_DEPTH; i++) slot_used[i] = 1'b0;
            aging_timeout = TIMEOUT_RST;
            pending_results.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch("status (none expected)", 64'(m_axis_tuser), 64'd0);
                end else begin
                    want = pending_results.pop_front();
                    if (m_axis_tuser !== want.status)
                        report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
                    if (m_axis_tdata[47:0] !== want.addr)
                        report_mismatch("expired_addr", 64'(m_axis_tdata[47:0]),
                                        64'(want.addr));
                    if (m_axis_tdata[52:48] !== want.count)
                        report_mismatch("entry_count", 64'(m_axis_tdata[52:48]),
                                        64'(want.count));
                    if (m_axis_tlast !== want.last)
                        report_mismatch("last", 64'(m_axis_tlast), 64'(want.last));
                end
            end
            if (psel && penable && pwrite && pready && paddr == TIMEOUT_ADDR)
                aging_timeout = pwdata[TIMEOUT_W-1:0];
            if (s_axis_tvalid && s_axis_tready)
                apply_table_op(t_op'(s_axis_tuser), s_axis_tdata[47:0], s_axis_tdata[79:48]);
        end
        o_pending    <= pending_results.size();
        o_fail_count <= fail_count;
    end

endmodule

[bench/tb_mac_table_with_aging.sv]
// ---------------------------------------------------------------------------
// tb_mac_table_with_aging
// Stimulus and verdict for the station address table with aging. A directed
// run covers empty, full, refresh, wrap and timeout boundary cases, then
// random phases under several timeouts mix learns, removes, sweeps and
// clears with random idling on both streams, one phase without idling and
// one long output hold-off. A separate checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_mac_table_with_aging;
    timeunit 1ns;
    timeprecision 1ps;

    import mta_pkg::*;

    localparam logic [2:0]           TIMEOUT_ADDR = 3'd0;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_EDGE = 23'd4294967;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_MAX  = '1;
    localparam int IDLE_PCT    = 24;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 42;
    localparam int N_PHASES    = 6;
    localparam int POOL_SIZE   = 20;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [2:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    logic quiet    = 1'b0;
    logic hold_req = 1'b0;
    int   fail_count;
    int   pending;
    int   stall_cycles = 0;

    logic [ADDR_W-1:0] station_pool [POOL_SIZE];
    logic [TIME_W-1:0] now_cur;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    mac_table_with_aging uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    mta_table_checker #(
        .TIMEOUT_ADDR (TIMEOUT_ADDR)
    ) checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    initial begin : receiver
        logic hold_seen;
        hold_seen = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_seen) begin
                hold_seen = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                if (!hold_req) hold_seen = 1'b0;
                m_axis_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (psel && penable))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_item(input t_op op, input logic [ADDR_W-1:0] station,
                             input logic [TIME_W-1:0] now);
        if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {now, station};
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic write_timeout(input logic [TIMEOUT_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TIMEOUT_ADDR;
        pwdata  <= {9'($urandom), value};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_random_phase(input int n_items);
        t_op               op;
        logic [ADDR_W-1:0] station;
        int                pick;
        for (int k = 0; k < n_items; k++) begin
            pick    = $urandom_range(0, 99);
            station = station_pool[$urandom_range(0, POOL_SIZE - 1)];
            if ($urandom_range(0, 9) == 0) station = ADDR_W'({$urandom, $urandom});
            if (pick < 50)
                op = OP_LEARN;
            else if (pick < 72)
                op = OP_SWEEP;
            else if (pick < 96)
                op = OP_REMOVE;
            else
                op = OP_CLEAR;
            if ($urandom_range(0, 19) == 0)
                now_cur = $urandom;
            else
                now_cur += $urandom_range(0, 1500);
            send_item(op, station, now_cur);
        end
    endtask

    initial begin : stimulus
        logic [TIMEOUT_W-1:0] phase_timeout [N_PHASES];
        for (int i = 0; i < POOL_SIZE; i++) station_pool[i] = ADDR_W'({$urandom, $urandom});
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_item(OP_SWEEP, ADDR_W'({$urandom, $urandom}), '0);
        send_item(OP_REMOVE, 48'h0000_0000_0123, 32'd1);
        send_item(OP_CLEAR, '1, 32'd2);
        send_item(OP_LEARN, '0, '0);
        send_item(OP_LEARN, '1, '1);
        send_item(OP_LEARN, '0, 32'd5);
        for (int i = 0; i < 14; i++) send_item(OP_LEARN, station_pool[i], 32'd100);
        send_item(OP_LEARN, station_pool[14], 32'd200);
        send_item(OP_REMOVE, '0, 32'd300);
        send_item(OP_SWEEP, '0, 32'd10000101);

        write_timeout(TIMEOUT_EDGE);
        send_item(OP_CLEAR, '0, '0);
        send_item(OP_LEARN, station_pool[15], '0);
        send_item(OP_SWEEP, '0, 32'd4294967000);
        send_item(OP_SWEEP, '0, 32'd4294967001);

        phase_timeout = '{23'd0, 23'd1, 23'd3, TIMEOUT_EDGE, TIMEOUT_MAX,
                          23'($urandom_range(1, 20))};
        for (int p = 0; p < N_PHASES; p++) begin
            write_timeout(phase_timeout[p]);
            quiet    <= (p == 3);
            hold_req <= (p == 2);
            now_cur = $urandom;
            run_random_phase(PHASE_ITEMS);
        end

        s_axis_tvalid <= 1'b0;
        quiet         <= 1'b0;
        hold_req      <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
